// ----- hw/rtl/skq_pkg.sv -----
// ----------------------------------------------------------------------------
// skq_pkg: shared types and constants of the speedup-keyed task queue
// Holds the transaction payloads, operation and status codes, register
// indexes and the record types passed between the queue modules.
// ----------------------------------------------------------------------------
package skq_pkg;

  localparam int QUEUE_CAP = 64;
  localparam int CNT_W     = $clog2(QUEUE_CAP + 1);
  localparam int KEY_W     = 16;
  localparam int HANDLE_W  = 16;
  localparam int THR_W     = 8;
  localparam int OP_W      = 2;
  localparam int ST_W      = 3;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT       = 2'd0,
    OP_TAKE_ACCEL   = 2'd1,
    OP_TAKE_GENERAL = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELIVERED = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_WITHHELD  = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Register indexes, selected by paddr[2]
  localparam logic REG_THREADS = 1'b0;
  localparam logic REG_BALANCE = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [HANDLE_W-1:0] task_handle;
    logic [KEY_W-1:0]    speedup_key;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [HANDLE_W-1:0] handle_out;
    logic [KEY_W-1:0]    key_out;
    count_t              queue_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem_head;
    logic   rem_tail;
    entry_t entry;
  } arr_cmd_t;

  typedef struct packed {
    count_t count;
    entry_t head;
    entry_t tail;
  } arr_sts_t;

  typedef struct packed {
    logic [THR_W-1:0] threads;
    logic             balance;
  } cfg_t;

endpackage

// ----- hw/rtl/skq_apb_regs.sv -----
// ----------------------------------------------------------------------------
// skq_apb_regs: configuration registers
// APB-style write/read of the accelerator thread count and balance enable.
// ----------------------------------------------------------------------------
module skq_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skq_pkg::ADDR_W-1:0]  paddr,
  input  logic [skq_pkg::DATA_W-1:0]  pwdata,
  output logic [skq_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output skq_pkg::cfg_t               cfg_o
);

  skq_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        skq_pkg::REG_THREADS: cfg_d.threads = pwdata[skq_pkg::THR_W-1:0];
        skq_pkg::REG_BALANCE: cfg_d.balance = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      skq_pkg::REG_THREADS: prdata = skq_pkg::DATA_W'(cfg_q.threads);
      skq_pkg::REG_BALANCE: prdata = skq_pkg::DATA_W'(cfg_q.balance);
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/skq_sort_array.sv -----
// ----------------------------------------------------------------------------
// skq_sort_array: register-held sorted entry array
// Entries sit in ascending key order from cell 0. Each cell compares its key
// with the incoming one and picks keep, new entry or a neighbor in parallel.
// ----------------------------------------------------------------------------
module skq_sort_array (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skq_pkg::arr_cmd_t cmd_i,
  output skq_pkg::arr_sts_t sts_o
);

  localparam int Cap = skq_pkg::QUEUE_CAP;

  skq_pkg::entry_t ent_q [Cap];
  skq_pkg::entry_t ent_d [Cap];
  skq_pkg::count_t count_q, count_d;
  logic [Cap-1:0]  le;
  skq_pkg::entry_t tail;

  for (genvar j = 0; j < Cap; j++) begin : g_cell
    skq_pkg::entry_t ins_val;
    skq_pkg::entry_t pop_val;

    // Occupied cell whose key does not exceed the new key: it stays put
    assign le[j] = (count_q > skq_pkg::count_t'(j)) &&
                   (ent_q[j].key <= cmd_i.entry.key);

    if (j == 0) begin : g_first
      assign ins_val = le[j] ? ent_q[j] : cmd_i.entry;
    end else begin : g_rest
      assign ins_val = le[j]   ? ent_q[j]    :
                       le[j-1] ? cmd_i.entry : ent_q[j-1];
    end

    if (j == Cap - 1) begin : g_last
      assign pop_val = ent_q[j];
    end else begin : g_inner
      assign pop_val = ent_q[j+1];
    end

    assign ent_d[j] = cmd_i.ins      ? ins_val :
                      cmd_i.rem_head ? pop_val : ent_q[j];
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + skq_pkg::count_t'(1);
    end else if (cmd_i.rem_head || cmd_i.rem_tail) begin
      count_d = count_q - skq_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // One-hot select of the last occupied cell
  always_comb begin
    tail = '0;
    for (int j = 0; j < Cap; j++) begin
      tail = skq_pkg::entry_t'(tail |
             (ent_q[j] & {$bits(skq_pkg::entry_t){count_q == skq_pkg::count_t'(j + 1)}}));
    end
  end

  assign sts_o.count = count_q;
  assign sts_o.head  = ent_q[0];
  assign sts_o.tail  = tail;

endmodule

// ----- hw/rtl/speedup_keyed_task_queue_core.sv -----
// ----------------------------------------------------------------------------
// speedup_keyed_task_queue_core: bounded double-ended priority task queue
// Keeps task handles sorted by speedup key; serves largest-key takes for the
// accelerator and smallest-key takes, with optional balancing, for the CPU.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------
//   in       | input     | in_valid_i / in_ready_o   | in_item_i  (in_item_t)
//   out      | output    | out_valid_o / out_ready_i | out_item_o (out_item_t)
//   cfg      | input     | psel, penable, pready     | paddr, pwdata, prdata
//
// One transaction per cycle while results are taken at once; each accepted
// item passes from the input register to the result register (out_valid_o).
// All work for an item is one pass through the sorted cell array compares.
// Reset empties the queue and clears both configuration registers.
// A stalled result holds in the result register while one more item waits
// in the input register; in_ready_o drops only when both are held.
// ----------------------------------------------------------------------------
module speedup_keyed_task_queue_core #(
  parameter int KEY_FRACTION_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  skq_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output skq_pkg::out_item_t          out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skq_pkg::ADDR_W-1:0]  paddr,
  input  logic [skq_pkg::DATA_W-1:0]  pwdata,
  output logic [skq_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int DemW = skq_pkg::THR_W + skq_pkg::KEY_W;
  localparam int SupW = skq_pkg::CNT_W + KEY_FRACTION_BITS;
  localparam int CmpW = (DemW > SupW) ? DemW : SupW;

  skq_pkg::cfg_t      cfg;
  skq_pkg::arr_cmd_t  cmd;
  skq_pkg::arr_sts_t  sts;

  skq_pkg::in_item_t  in_q;
  logic               in_vld_q, in_vld_d;
  skq_pkg::out_item_t out_q, res;
  logic               out_vld_q, out_vld_d;
  logic               out_free, fire;

  logic [DemW-1:0]    product;
  logic [CmpW-1:0]    demand, supply;
  logic               withhold;
  logic               full, empty;

  skq_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  skq_sort_array u_array (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  assign out_free   = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  // Input register
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // Balancing guard: threads * head key against count, both in key scale
  assign product  = DemW'(cfg.threads) * DemW'(sts.head.key);
  assign demand   = CmpW'(product);
  assign supply   = CmpW'(sts.count) << KEY_FRACTION_BITS;
  assign withhold = cfg.balance && (demand > supply);

  assign full  = (sts.count >= skq_pkg::count_t'(skq_pkg::QUEUE_CAP));
  assign empty = (sts.count == '0);

  always_comb begin
    cmd              = '0;
    cmd.entry.key    = in_q.speedup_key;
    cmd.entry.handle = in_q.task_handle;
    res              = '0;
    res.status       = skq_pkg::ST_EMPTY;
    res.queue_count  = sts.count;
    case (in_q.operation)
      skq_pkg::OP_INSERT: begin
        if (full) begin
          res.status = skq_pkg::ST_FULL;
        end else begin
          cmd.ins         = fire;
          res.status      = skq_pkg::ST_INSERTED;
          res.queue_count = sts.count + skq_pkg::count_t'(1);
        end
      end
      skq_pkg::OP_TAKE_ACCEL: begin
        if (!empty) begin
          cmd.rem_tail    = fire;
          res.status      = skq_pkg::ST_DELIVERED;
          res.handle_out  = sts.tail.handle;
          res.key_out     = sts.tail.key;
          res.queue_count = sts.count - skq_pkg::count_t'(1);
        end
      end
      skq_pkg::OP_TAKE_GENERAL: begin
        if (!empty) begin
          if (withhold) begin
            res.status = skq_pkg::ST_WITHHELD;
          end else begin
            cmd.rem_head    = fire;
            res.status      = skq_pkg::ST_DELIVERED;
            res.handle_out  = sts.head.handle;
            res.key_out     = sts.head.key;
            res.queue_count = sts.count - skq_pkg::count_t'(1);
          end
        end
      end
      default: res.status = skq_pkg::ST_EMPTY;
    endcase
  end

  // Result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= skq_pkg::count_t'(skq_pkg::QUEUE_CAP))
    else $error("queue count above capacity");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.ins, cmd.rem_head, cmd.rem_tail}))
    else $error("more than one array command at once");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> sts.count == $past(sts.count) + skq_pkg::count_t'(1))
    else $error("insert did not advance the count");

  a_count_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_item_o.queue_count == sts.count)
    else $error("reported count differs from held count");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_free |=> in_vld_q && $stable(in_q))
    else $error("pending input transaction lost during stall");

  a_no_delivery_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status != skq_pkg::ST_DELIVERED |->
      out_q.handle_out == '0 && out_q.key_out == '0)
    else $error("payload set on a result without delivery");

endmodule

// ----- sim/tb_speedup_keyed_task_queue_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_speedup_keyed_task_queue_core: self-checking bench of the task queue
// Drives scheduler requests over valid/ready and writes the balancing
// registers over APB. A sorted shadow queue predicts every result, and each
// result is compared field by field with the oldest prediction. Directed
// cases cover the empty, full, equal-key and balancing corners. Random phases
// then run under several register settings, mostly with send gaps and stalls.
// ----------------------------------------------------------------------------
module tb_speedup_keyed_task_queue_core;

  localparam int KEY_FRAC_BITS = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 80;
  localparam int SHOWN_ERRORS  = 10;
  // operation code with no meaning; the block must treat it as a no-op
  localparam logic [skq_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  skq_pkg::in_item_t            in_item_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  skq_pkg::out_item_t           out_item_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [skq_pkg::ADDR_W-1:0]   paddr;
  logic [skq_pkg::DATA_W-1:0]   pwdata;
  logic [skq_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  skq_pkg::entry_t              held_entries[$];
  skq_pkg::out_item_t           expected_results[$];
  logic [skq_pkg::THR_W-1:0]    threads_cfg = '0;
  logic                         balance_cfg = 1'b0;
  int                           mismatch_count = 0;
  int                           cycle_count = 0;
  bit                           send_gaps_on = 1'b1;
  bit                           recv_stalls_on = 1'b1;
  bit                           long_hold_req = 1'b0;

  speedup_keyed_task_queue_core #(
    .KEY_FRACTION_BITS(KEY_FRAC_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Shadow queue: ascending keys, inserts go after equal keys
  function automatic skq_pkg::out_item_t apply_task_request(skq_pkg::in_item_t req);
    skq_pkg::out_item_t res;
    skq_pkg::entry_t    ent;
    int                 pos;
    logic [31:0]        demand;
    logic [31:0]        supply;
    res = '0;
    case (req.operation)
      skq_pkg::OP_INSERT: begin
        if (held_entries.size() >= skq_pkg::QUEUE_CAP) begin
          res.status = skq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_entries.size() && held_entries[pos].key <= req.speedup_key)
            pos++;
          ent.key    = req.speedup_key;
          ent.handle = req.task_handle;
          held_entries.insert(pos, ent);
          res.status = skq_pkg::ST_INSERTED;
        end
      end
      skq_pkg::OP_TAKE_ACCEL: begin
        if (held_entries.size() == 0) begin
          res.status = skq_pkg::ST_EMPTY;
        end else begin
          ent = held_entries[held_entries.size() - 1];
          held_entries.delete(held_entries.size() - 1);
          res.status     = skq_pkg::ST_DELIVERED;
          res.handle_out = ent.handle;
          res.key_out    = ent.key;
        end
      end
      skq_pkg::OP_TAKE_GENERAL: begin
        if (held_entries.size() == 0) begin
          res.status = skq_pkg::ST_EMPTY;
        end else begin
          ent    = held_entries[0];
          demand = 32'(threads_cfg) * 32'(ent.key);
          supply = 32'(held_entries.size()) << KEY_FRAC_BITS;
          if (balance_cfg && demand > supply) begin
            res.status = skq_pkg::ST_WITHHELD;
          end else begin
            held_entries.delete(0);
            res.status     = skq_pkg::ST_DELIVERED;
            res.handle_out = ent.handle;
            res.key_out    = ent.key;
          end
        end
      end
      default: res.status = skq_pkg::ST_EMPTY;
    endcase
    res.queue_count = skq_pkg::count_t'(held_entries.size());
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS)
        $display("mismatch in %s at cycle %0d: expected 0x%0h, got 0x%0h",
                 name, cycle_count, exp_val, act_val);
    end
  endtask

  // Predict on each accepted request, then check each accepted result
  always @(posedge clk_i) begin : result_monitor
    skq_pkg::out_item_t exp_res;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_results.insert(expected_results.size(), apply_task_request(in_item_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS)
            $display("unexpected result at cycle %0d: status %0d handle 0x%0h",
                     cycle_count, out_item_o.status, out_item_o.handle_out);
        end else begin
          exp_res = expected_results[0];
          expected_results.delete(0);
          check_field("status", 32'(exp_res.status), 32'(out_item_o.status));
          check_field("handle_out", 32'(exp_res.handle_out), 32'(out_item_o.handle_out));
          check_field("key_out", 32'(exp_res.key_out), 32'(out_item_o.key_out));
          check_field("queue_count", 32'(exp_res.queue_count),
                      32'(out_item_o.queue_count));
        end
      end
    end
  end

  function automatic int random_gap(bit enabled);
    int pick;
    if (!enabled)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 0;
    if (pick < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_receiver
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        stall = random_gap(recv_stalls_on);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [skq_pkg::OP_W-1:0] op,
                              logic [skq_pkg::HANDLE_W-1:0] handle,
                              logic [skq_pkg::KEY_W-1:0] key);
    int gap;
    in_valid_i            <= 1'b1;
    in_item_i.operation   <= op;
    in_item_i.task_handle <= handle;
    in_item_i.speedup_key <= key;
    do @(posedge clk_i); while (!in_ready_o);
    gap = random_gap(send_gaps_on);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold until every predicted result has been checked
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic reg_sel, logic [skq_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == skq_pkg::REG_THREADS)
      threads_cfg = value[skq_pkg::THR_W-1:0];
    else
      balance_cfg = value[0];
    @(posedge clk_i);
  endtask

  task automatic set_balancing(logic [skq_pkg::THR_W-1:0] threads, logic enable);
    wait_idle();
    cfg_write(skq_pkg::REG_THREADS, skq_pkg::DATA_W'(threads));
    cfg_write(skq_pkg::REG_BALANCE, skq_pkg::DATA_W'(enable));
  endtask

  function automatic logic [skq_pkg::HANDLE_W-1:0] random_handle();
    return skq_pkg::HANDLE_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Mix of tiny keys (ties), small keys (guard passes) and full-range keys
  function automatic logic [skq_pkg::KEY_W-1:0] random_key();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h0100;
          default: return 16'h0080;
        endcase
      end
      1: return skq_pkg::KEY_W'($urandom_range(0, 16'h03FF));
      default: return skq_pkg::KEY_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic random_request(int insert_pct);
    int                         pick;
    logic [skq_pkg::OP_W-1:0]   op;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      op = OP_RESERVED;
    else if (pick < 3 + insert_pct)
      op = skq_pkg::OP_INSERT;
    else if ($urandom_range(0, 1) == 0)
      op = skq_pkg::OP_TAKE_ACCEL;
    else
      op = skq_pkg::OP_TAKE_GENERAL;
    send_request(op, random_handle(), random_key());
  endtask

  task automatic test_empty_takes();
    send_request(skq_pkg::OP_TAKE_ACCEL, 16'hFFFF, 16'hFFFF);
    send_request(skq_pkg::OP_TAKE_GENERAL, 16'h0000, 16'h0000);
    send_request(OP_RESERVED, 16'hA5A5, 16'h5A5A);
  endtask

  // Equal keys: accelerator gets the newest, general processor the oldest
  task automatic test_insert_order();
    send_request(skq_pkg::OP_INSERT, 16'h0000, 16'h0000);
    send_request(skq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF);
    send_request(skq_pkg::OP_INSERT, 16'h1234, 16'h0100);
    send_request(skq_pkg::OP_INSERT, 16'h5678, 16'h0100);
    send_request(skq_pkg::OP_INSERT, 16'hABCD, 16'h0100);
    send_request(skq_pkg::OP_TAKE_ACCEL, 16'h0000, 16'h0000);
    send_request(skq_pkg::OP_TAKE_ACCEL, 16'h0000, 16'h0000);
    send_request(skq_pkg::OP_TAKE_GENERAL, 16'hFFFF, 16'hFFFF);
    send_request(skq_pkg::OP_TAKE_GENERAL, 16'h0000, 16'h0000);
    send_request(skq_pkg::OP_TAKE_ACCEL, 16'h0000, 16'h0000);
    send_request(skq_pkg::OP_TAKE_ACCEL, 16'h0000, 16'h0000);
  endtask

  // Fill past capacity while results are held off, then drain past empty
  task automatic test_fill_and_reject();
    int n_fill;
    wait_idle();
    send_gaps_on = 1'b0;
    long_hold_req = 1'b1;
    n_fill = skq_pkg::QUEUE_CAP - held_entries.size() + 3;
    repeat (n_fill)
      send_request(skq_pkg::OP_INSERT, random_handle(), random_key());
    send_gaps_on = 1'b1;
    repeat (skq_pkg::QUEUE_CAP + 2)
      send_request($urandom_range(0, 1) ? skq_pkg::OP_TAKE_ACCEL : skq_pkg::OP_TAKE_GENERAL,
                   16'h0, 16'h0);
  endtask

  // One thread, one entry: key 1.0 just passes, one LSB more is withheld
  task automatic test_balance_boundary();
    set_balancing(8'd1, 1'b1);
    send_request(skq_pkg::OP_INSERT, 16'h2222, 16'h0101);
    send_request(skq_pkg::OP_TAKE_GENERAL, 16'h0, 16'h0);
    send_request(skq_pkg::OP_TAKE_ACCEL, 16'h0, 16'h0);
    send_request(skq_pkg::OP_INSERT, 16'h3333, 16'h0100);
    send_request(skq_pkg::OP_TAKE_GENERAL, 16'h0, 16'h0);
  endtask

  task automatic test_random_mix();
    set_balancing(8'd0, 1'b1);
    repeat (90) random_request(60);
    set_balancing(8'd255, 1'b1);
    repeat (90) random_request(65);
    set_balancing(8'd1, 1'b1);
    repeat (90) random_request(55);
    set_balancing(8'd3, 1'b1);
    send_gaps_on = 1'b0;
    recv_stalls_on = 1'b0;
    repeat (60) random_request(55);
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
    set_balancing(8'd255, 1'b0);
    repeat (60) random_request(45);
  endtask

  // Sender pauses between bursts until all results are back
  task automatic test_paused_sender();
    repeat (20) random_request(50);
    wait_idle();
    repeat (20) random_request(40);
  endtask

  initial begin : test_sequence
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_takes();
    test_insert_order();
    test_fill_and_reject();
    test_balance_boundary();
    test_random_mix();
    test_paused_sender();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
